### src/qslp_pkg.sv
// Shared types, constants and the Q30 multiply helper for the slerp pipeline.
// Used by qslp_sin, qslp_div and quaternion_slerp; depends on nothing.
package qslp_pkg;

    localparam int SIN_LAT = 6;   // register stages in one sine unit
    localparam int QUOT_W  = 34;  // quotient bits from the weight divider
    localparam int ITER    = 16;  // angle bits resolved by the acos search
    localparam int FRAC    = 30;  // fraction bits of the weight format

    localparam logic signed [31:0] SIN_A1 = 32'sd1686629713;
    localparam logic signed [31:0] SIN_A3 = 32'sd693598668;
    localparam logic signed [31:0] SIN_A5 = 32'sd85569306;
    localparam logic signed [31:0] SIN_A7 = 32'sd5026995;
    localparam logic signed [31:0] SIN_A9 = 32'sd172272;
    localparam logic [30:0]        Q30_ONE = 31'h4000_0000;
    localparam logic [14:0]        THR_RESET = 15'd16382;
    localparam logic [15:0]        BLEND_ONE = 16'h8000;

    typedef struct packed {
        logic signed [15:0] a_x;
        logic signed [15:0] a_y;
        logic signed [15:0] a_z;
        logic signed [15:0] a_w;
        logic signed [15:0] b_x;
        logic signed [15:0] b_y;
        logic signed [15:0] b_z;
        logic signed [15:0] b_w;
        logic [15:0]        blend;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] q_x;
        logic signed [15:0] q_y;
        logic signed [15:0] q_z;
        logic signed [15:0] q_w;
    } out_word_t;

    // Context that travels with each item down the pipeline.
    typedef struct packed {
        logic [3:0][15:0] a;
        logic [3:0][15:0] b;
        logic [15:0]      t;
        logic             neg;
        logic             lin;
        logic [30:0]      c;
        logic [15:0]      w;
    } ctx_t;

    // (a*b) >> 30, truncated toward zero, sign-magnitude as the format asks.
    function automatic logic signed [31:0] mul_q30(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic [31:0] ua;
        logic [31:0] ub;
        logic [63:0] prod;
        logic [31:0] m;
        ua   = a[31] ? $unsigned(-a) : $unsigned(a);
        ub   = b[31] ? $unsigned(-b) : $unsigned(b);
        prod = ua * ub;
        m    = prod[61:30];
        return (a[31] ^ b[31]) ? -$signed(m) : $signed(m);
    endfunction

endpackage

### src/qslp_sin.sv
// Six-stage pipelined polynomial sine of an angle given in units of pi/2/65536.
// Depends on qslp_pkg (coefficients, mul_q30).
module qslp_sin (
    input  logic        clk,
    input  logic        en,
    input  logic [16:0] u,
    output logic [30:0] sin_val
);
    import qslp_pkg::*;

    logic signed [31:0] x_reg  [SIN_LAT-1];
    logic signed [31:0] x2_reg [SIN_LAT-2];
    logic signed [31:0] p_reg  [1:SIN_LAT-2];
    logic signed [31:0] x0;
    logic signed [31:0] pm;
    logic [30:0]        sin_next;
    logic [30:0]        sin_reg;

    assign x0 = $signed({1'b0, u, 14'b0});
    assign pm = mul_q30(x_reg[SIN_LAT-2], p_reg[SIN_LAT-2]);

    always_comb
    begin
        if (pm < 0)
            sin_next = '0;
        else if (pm > $signed({1'b0, Q30_ONE}))
            sin_next = Q30_ONE;
        else
            sin_next = pm[30:0];
    end

    // Horner chain, one multiply per stage.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]  <= x0;
            x2_reg[0] <= mul_q30(x0, x0);
            for (int i = 1; i < SIN_LAT - 1; i++)
                x_reg[i] <= x_reg[i-1];
            for (int i = 1; i < SIN_LAT - 2; i++)
                x2_reg[i] <= x2_reg[i-1];
            p_reg[1] <= -SIN_A7 + mul_q30(x2_reg[0], SIN_A9);
            p_reg[2] <=  SIN_A5 + mul_q30(x2_reg[1], p_reg[1]);
            p_reg[3] <= -SIN_A3 + mul_q30(x2_reg[2], p_reg[2]);
            p_reg[4] <=  SIN_A1 + mul_q30(x2_reg[3], p_reg[3]);
            sin_reg  <= sin_next;
        end
    end

    assign sin_val = sin_reg;

endmodule

### src/qslp_div.sv
// Restoring divider, one quotient bit per stage: quo = (num << 30) / den.
// Depends on qslp_pkg (QUOT_W, FRAC).
module qslp_div (
    input  logic                           clk,
    input  logic                           en,
    input  logic [30:0]                    num,
    input  logic [30:0]                    den,
    output logic [qslp_pkg::QUOT_W-1:0]    quo
);
    import qslp_pkg::*;

    localparam int HI = QUOT_W - FRAC;

    logic [30:0]       rem_reg [QUOT_W];
    logic [30:0]       num_reg [QUOT_W];
    logic [30:0]       den_reg [QUOT_W];
    logic [QUOT_W-1:0] q_reg   [QUOT_W];

    for (genvar j = 0; j < QUOT_W; j++)
    begin : g_stage
        localparam int B = QUOT_W - 1 - j;
        logic [30:0]       rem_in;
        logic [30:0]       num_in;
        logic [30:0]       den_in;
        logic [QUOT_W-1:0] q_in;
        logic              nbit;
        logic [31:0]       r;
        logic              ge;
        logic [30:0]       rem_next;
        logic [QUOT_W-1:0] q_next;

        if (j == 0)
        begin : g_first
            assign rem_in = num >> HI;
            assign num_in = num;
            assign den_in = den;
            assign q_in   = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[j-1];
            assign num_in = num_reg[j-1];
            assign den_in = den_reg[j-1];
            assign q_in   = q_reg[j-1];
        end

        if (B >= FRAC)
        begin : g_nbit
            assign nbit = num_in[B-FRAC];
        end
        else
        begin : g_zero
            assign nbit = 1'b0;
        end

        always_comb
        begin
            r        = {rem_in, nbit};
            ge       = (r >= {1'b0, den_in});
            rem_next = ge ? 31'(r - {1'b0, den_in}) : r[30:0];
            q_next   = q_in;
            q_next[B] = ge;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j] <= rem_next;
                num_reg[j] <= num_in;
                den_reg[j] <= den_in;
                q_reg[j]   <= q_next;
            end
        end
    end

    assign quo = q_reg[QUOT_W-1];

endmodule

### src/quaternion_slerp.sv
// Quaternion slerp: a fully pipelined datapath built from qslp_sin and qslp_div.
// Depends on qslp_pkg for word types, constants and the Q30 multiply.
// Throughput: one word per cycle while no result word waits on a stalled
// consumer; the 16-step acos search (six sine stages per step) and the 34-stage
// weight divider set the depth, not the rate.
// Reset: rst_n clears all valid bits and loads the threshold with 16382.
module quaternion_slerp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  qslp_pkg::in_word_t    in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output qslp_pkg::out_word_t   out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [14:0]           cfg_data
);
    import qslp_pkg::*;

    // Whole pipeline advances together; hold everything while a result
    // word waits on a stalled consumer.
    logic en;
    assign en       = !out_valid || !out_stall;
    assign in_stall = !en;

    // Threshold register; the port never pushes back.
    logic [14:0] thr_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= THR_RESET;
        else if (cfg_valid)
            thr_reg <= cfg_data;
    end

    // ---------------- Stage 1: products of the dot, clamp blend
    logic               s1_vld_reg;
    logic signed [31:0] prod_reg [4];
    ctx_t               ctx1_reg;
    ctx_t               ctx1_next;

    always_comb
    begin
        ctx1_next      = '0;
        ctx1_next.a[0] = in_data.a_x;
        ctx1_next.a[1] = in_data.a_y;
        ctx1_next.a[2] = in_data.a_z;
        ctx1_next.a[3] = in_data.a_w;
        ctx1_next.b[0] = in_data.b_x;
        ctx1_next.b[1] = in_data.b_y;
        ctx1_next.b[2] = in_data.b_z;
        ctx1_next.b[3] = in_data.b_w;
        // Blend above one counts as one.
        ctx1_next.t    = (in_data.blend > BLEND_ONE) ? BLEND_ONE : in_data.blend;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx1_reg    <= ctx1_next;
            prod_reg[0] <= in_data.a_x * in_data.b_x;
            prod_reg[1] <= in_data.a_y * in_data.b_y;
            prod_reg[2] <= in_data.a_z * in_data.b_z;
            prod_reg[3] <= in_data.a_w * in_data.b_w;
        end
    end

    // ---------------- Stage 2: dot sum, magnitude, linear test, acos target
    logic               s2_vld_reg;
    ctx_t               ctx2_reg;
    ctx_t               ctx2_next;
    logic signed [33:0] dot;
    logic [32:0]        mag;

    always_comb
    begin
        dot = 34'(prod_reg[0]) + 34'(prod_reg[1]) + 34'(prod_reg[2]) + 34'(prod_reg[3]);
        mag = dot[33] ? 33'(-dot) : 33'(dot);
        ctx2_next     = ctx1_reg;
        ctx2_next.neg = dot[33];
        ctx2_next.lin = (mag > {4'b0, thr_reg, 14'b0});
        // Clamp the dot at one before acos.
        ctx2_next.c   = (mag > 33'h1000_0000) ? Q30_ONE : {mag[28:0], 2'b00};
        ctx2_next.w   = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            ctx2_reg <= ctx2_next;
    end

    // ---------------- acos: keep a candidate bit while sin(pi/2 - cand) >= c
    ctx_t            iter_ctx [ITER+1];
    logic [ITER:0]   iter_vld;

    assign iter_ctx[0] = ctx2_reg;
    assign iter_vld[0] = s2_vld_reg;

    for (genvar k = 0; k < ITER; k++)
    begin : g_acos
        localparam int B = ITER - 1 - k;
        logic [15:0]        bitmask;
        logic [16:0]        u;
        logic [30:0]        s_val;
        ctx_t               dly_reg [SIN_LAT];
        logic [SIN_LAT-1:0] vld_reg;
        ctx_t               nxt;

        assign bitmask = 16'(1) << B;
        assign u       = 17'h1_0000 - {1'b0, iter_ctx[k].w | bitmask};

        qslp_sin u_sin (
            .clk     (clk),
            .en      (en),
            .u       (u),
            .sin_val (s_val)
        );

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg <= '0;
            else if (en)
                vld_reg <= {vld_reg[SIN_LAT-2:0], iter_vld[k]};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dly_reg[0] <= iter_ctx[k];
                for (int i = 1; i < SIN_LAT; i++)
                    dly_reg[i] <= dly_reg[i-1];
            end
        end

        always_comb
        begin
            nxt = dly_reg[SIN_LAT-1];
            if (s_val >= nxt.c)
                nxt.w = nxt.w | bitmask;
        end

        assign iter_ctx[k+1] = nxt;
        assign iter_vld[k+1] = vld_reg[SIN_LAT-1];
    end

    // ---------------- W1: hold the angle; W2: scale it by t and 1-t
    logic        w1_vld_reg;
    ctx_t        w1_ctx_reg;
    logic        w2_vld_reg;
    ctx_t        w2_ctx_reg;
    logic [16:0] wt_reg;
    logic [16:0] w1t_reg;
    logic [31:0] wt_prod;
    logic [31:0] w1t_prod;

    assign wt_prod  = w1_ctx_reg.w * w1_ctx_reg.t;
    assign w1t_prod = w1_ctx_reg.w * 16'(BLEND_ONE - w1_ctx_reg.t);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w1_ctx_reg <= iter_ctx[ITER];
            w2_ctx_reg <= w1_ctx_reg;
            wt_reg     <= wt_prod[31:15];
            w1t_reg    <= w1t_prod[31:15];
        end
    end

    // ---------------- Three sines in parallel
    logic [30:0]        sw;
    logic [30:0]        sn1;
    logic [30:0]        sn2;
    ctx_t               sn_dly_reg [SIN_LAT];
    logic [SIN_LAT-1:0] sn_vld_reg;

    qslp_sin u_sin_w   (.clk(clk), .en(en), .u({1'b0, w2_ctx_reg.w}), .sin_val(sw));
    qslp_sin u_sin_w1t (.clk(clk), .en(en), .u(w1t_reg),              .sin_val(sn1));
    qslp_sin u_sin_wt  (.clk(clk), .en(en), .u(wt_reg),               .sin_val(sn2));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sn_dly_reg[0] <= w2_ctx_reg;
            for (int i = 1; i < SIN_LAT; i++)
                sn_dly_reg[i] <= sn_dly_reg[i-1];
        end
    end

    // ---------------- Divide both weights by sin(omega)
    ctx_t              dv_in;
    ctx_t              dv_dly_reg [QUOT_W];
    logic [QUOT_W-1:0] dv_vld_reg;
    logic [QUOT_W-1:0] q1;
    logic [QUOT_W-1:0] q2;

    always_comb
    begin
        dv_in = sn_dly_reg[SIN_LAT-1];
        // Zero sine of omega falls back to linear weights.
        if (sw == '0)
            dv_in.lin = 1'b1;
    end

    qslp_div u_div1 (.clk(clk), .en(en), .num(sn1), .den(sw), .quo(q1));
    qslp_div u_div2 (.clk(clk), .en(en), .num(sn2), .den(sw), .quo(q2));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_dly_reg[0] <= dv_in;
            for (int i = 1; i < QUOT_W; i++)
                dv_dly_reg[i] <= dv_dly_reg[i-1];
        end
    end

    // ---------------- F1: pick weights, negate b's weight for the short path
    ctx_t               f1_ctx_reg;
    logic               f1_vld_reg;
    logic signed [34:0] wt1_reg;
    logic signed [34:0] wt2_reg;
    logic signed [34:0] wt1_next;
    logic signed [34:0] wt2_next;
    ctx_t               f_in;

    always_comb
    begin
        f_in = dv_dly_reg[QUOT_W-1];
        if (f_in.lin)
        begin
            wt1_next = $signed({4'b0, 16'(BLEND_ONE - f_in.t), 15'b0});
            wt2_next = $signed({4'b0, f_in.t, 15'b0});
        end
        else
        begin
            wt1_next = $signed({1'b0, q1});
            wt2_next = $signed({1'b0, q2});
        end
        if (f_in.neg)
            wt2_next = -wt2_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_ctx_reg <= f_in;
            wt1_reg    <= wt1_next;
            wt2_reg    <= wt2_next;
        end
    end

    // ---------------- F2: weighted components
    logic               f2_vld_reg;
    logic signed [50:0] pa_reg [4];
    logic signed [50:0] pb_reg [4];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                pa_reg[i] <= wt1_reg * $signed(f1_ctx_reg.a[i]);
                pb_reg[i] <= wt2_reg * $signed(f1_ctx_reg.b[i]);
            end
        end
    end

    // ---------------- F3: sum, round to Q2.14, saturate into the output word
    logic [3:0][15:0] res;

    always_comb
    begin
        logic signed [51:0] acc;
        logic signed [21:0] r;
        res = '0;
        for (int i = 0; i < 4; i++)
        begin
            acc = 52'(pa_reg[i]) + 52'(pb_reg[i]) + 52'sh2000_0000;
            r   = acc[51:30];
            if (r > 22'sd32767)
                res[i] = 16'h7FFF;
            else if (r < -22'sd32768)
                res[i] = 16'h8000;
            else
                res[i] = r[15:0];
        end
    end

    out_word_t out_reg;
    logic      out_vld_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg.q_x <= res[0];
            out_reg.q_y <= res[1];
            out_reg.q_z <= res[2];
            out_reg.q_w <= res[3];
        end
    end

    // Valid bits of the fixed stages; the iterated sections keep their own.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            w1_vld_reg  <= 1'b0;
            w2_vld_reg  <= 1'b0;
            sn_vld_reg  <= '0;
            dv_vld_reg  <= '0;
            f1_vld_reg  <= 1'b0;
            f2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg  <= in_valid;
            s2_vld_reg  <= s1_vld_reg;
            w1_vld_reg  <= iter_vld[ITER];
            w2_vld_reg  <= w1_vld_reg;
            sn_vld_reg  <= {sn_vld_reg[SIN_LAT-2:0], w2_vld_reg};
            dv_vld_reg  <= {dv_vld_reg[QUOT_W-2:0], sn_vld_reg[SIN_LAT-1]};
            f1_vld_reg  <= dv_vld_reg[QUOT_W-1];
            f2_vld_reg  <= f1_vld_reg;
            out_vld_reg <= f2_vld_reg;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

    logic signed [34:0] wsum;
    assign wsum = wt1_reg + (f1_ctx_reg.neg ? -wt2_reg : wt2_reg);

`ifndef NO_ASSERTIONS
    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |=> thr_reg == $past(cfg_data))
        else $error("threshold write lost");

    a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> in_stall)
        else $error("input taken while output word blocked");

    a_lin_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (f1_vld_reg && f1_ctx_reg.lin) |-> wsum == 35'sh4000_0000)
        else $error("linear weights do not sum to one");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!en && f2_vld_reg) |=> f2_vld_reg && out_vld_reg)
        else $error("pipeline moved during stall");
`endif

endmodule

### dv/slerp_checker.sv
// Checker for quaternion_slerp: predicts each result word from the accepted
// input words and compares it with the block's output. Depends on qslp_pkg.
`timescale 1ns / 100ps

module slerp_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  qslp_pkg::in_word_t  in_data,
    input  logic                out_valid,
    input  logic                out_stall,
    input  qslp_pkg::out_word_t out_data,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [14:0]         cfg_data,
    output int                  pending,
    output int                  fail_count
);
    import qslp_pkg::*;

    logic [14:0]  fallback_thr;
    out_word_t    expected_quats[$];
    int           mismatches;

    function automatic longint mul30(input longint a, input longint b);
        longint unsigned ua;
        longint unsigned ub;
        longint m;
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        m  = longint'((ua * ub) >> 30);
        return ((a < 0) != (b < 0)) ? -m : m;
    endfunction

    // sine of u * (pi/2) / 65536 in Q2.30, clamped to [0, 1.0]
    function automatic longint sine_q30(input longint u);
        longint x;
        longint x2;
        longint p;
        x  = u <<< 14;
        x2 = mul30(x, x);
        p  = SIN_A9;
        p  = -longint'(SIN_A7) + mul30(x2, p);
        p  = longint'(SIN_A5) + mul30(x2, p);
        p  = -longint'(SIN_A3) + mul30(x2, p);
        p  = longint'(SIN_A1) + mul30(x2, p);
        p  = mul30(x, p);
        if (p < 0) p = 0;
        if (p > (64'sd1 <<< 30)) p = 64'sd1 <<< 30;
        return p;
    endfunction

    function automatic out_word_t slerp_predict(input in_word_t w, input logic [14:0] thr);
        longint    a[4];
        longint    b[4];
        longint    d;
        longint    mag;
        longint    c;
        longint    s1;
        longint    s2;
        longint    sw;
        longint    acc;
        longint    r;
        longint    t;
        longint    omega;
        longint    cand;
        logic      linear;
        out_word_t q;
        a = '{w.a_x, w.a_y, w.a_z, w.a_w};
        b = '{w.b_x, w.b_y, w.b_z, w.b_w};
        d = 0;
        for (int i = 0; i < 4; i++) d += a[i] * b[i];
        t = w.blend;
        if (t > 32768) t = 32768;
        mag    = (d < 0) ? -d : d;
        linear = mag > (longint'(thr) <<< 14);
        s1 = 0;
        s2 = 0;
        if (!linear)
        begin
            c = (mag > (64'sd1 <<< 28)) ? (64'sd1 <<< 30) : (mag <<< 2);
            omega = 0;
            // resolve acos one bit at a time, msb first
            for (int bit_i = 15; bit_i >= 0; bit_i--)
            begin
                cand = omega | (64'sd1 <<< bit_i);
                if (sine_q30(65536 - cand) >= c) omega = cand;
            end
            sw = sine_q30(omega);
            if (sw == 0)
                linear = 1'b1;
            else
            begin
                s1 = (sine_q30((omega * (32768 - t)) >>> 15) <<< 30) / sw;
                s2 = (sine_q30((omega * t) >>> 15) <<< 30) / sw;
            end
        end
        if (linear)
        begin
            s1 = (32768 - t) <<< 15;
            s2 = t <<< 15;
        end
        if (d < 0) s2 = -s2;
        for (int i = 0; i < 4; i++)
        begin
            acc = s1 * a[i] + s2 * b[i];
            r   = (acc + (64'sd1 <<< 29)) >>> 30;
            if (r > 32767) r = 32767;
            if (r < -32768) r = -32768;
            case (i)
                0: q.q_x = r[15:0];
                1: q.q_y = r[15:0];
                2: q.q_z = r[15:0];
                default: q.q_w = r[15:0];
            endcase
        end
        return q;
    endfunction

    assign pending = expected_quats.size();

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t exp_q;
        if (!rst_n)
        begin
            fallback_thr = THR_RESET;
            expected_quats.delete();
            fail_count = 0;
            mismatches = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready) fallback_thr = cfg_data;
            if (in_valid && !in_stall)
                expected_quats.push_back(slerp_predict(in_data, fallback_thr));
            if (out_valid && !out_stall)
            begin
                if (expected_quats.size() == 0)
                begin
                    fail_count++;
                    $display("unexpected result word %h", out_data);
                end
                else
                begin
                    exp_q = expected_quats.pop_front();
                    if (exp_q.q_x !== out_data.q_x || exp_q.q_y !== out_data.q_y ||
                        exp_q.q_z !== out_data.q_z || exp_q.q_w !== out_data.q_w)
                    begin
                        fail_count++;
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected x=%0d y=%0d z=%0d w=%0d, got x=%0d y=%0d z=%0d w=%0d",
                                     exp_q.q_x, exp_q.q_y, exp_q.q_z, exp_q.q_w,
                                     out_data.q_x, out_data.q_y, out_data.q_z, out_data.q_w);
                    end
                end
            end
        end
    end
endmodule

### dv/tb_quaternion_slerp.sv
// Testbench top for quaternion_slerp: drives input and config words and the
// result-side stall, instantiates the block and slerp_checker. Depends on qslp_pkg.
`timescale 1ns / 100ps

module tb_quaternion_slerp;
    import qslp_pkg::*;

    localparam int LATENCY    = 143;
    localparam int IDLE_LIMIT = 5000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_word_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_word_t   out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [14:0] cfg_data;
    int          pending;
    int          fail_count;
    int          idle_cycles;
    int          stall_left;
    logic        no_idle;   // stretch with no gaps on either side

    quaternion_slerp u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    slerp_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .pending    (pending),
        .fail_count (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Result side: hold stall for a drawn number of cycles per result word.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_stall <= 1'b0;
            if (out_valid && !out_stall)
                stall_left <= no_idle ? 0 : $urandom_range(0, 14);
        end
    end

    // Watchdog: count cycles with no word moving on any channel.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("[quaternion_slerp] ERROR");
                $finish;
            end
        end
    end

    // Push one input word, then drop valid for the drawn gap.
    task automatic send_word(input in_word_t w);
        int gap;
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        gap = no_idle ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Let the pipeline drain fully before touching the threshold.
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [14:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic in_word_t make_word(input int sa[4], input int sb[4], input int t);
        in_word_t w;
        w.a_x = 16'(sa[0]); w.a_y = 16'(sa[1]); w.a_z = 16'(sa[2]); w.a_w = 16'(sa[3]);
        w.b_x = 16'(sb[0]); w.b_y = 16'(sb[1]); w.b_z = 16'(sb[2]); w.b_w = 16'(sb[3]);
        w.blend = 16'(t);
        return w;
    endfunction

    function automatic int pick_blend();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return int'(BLEND_ONE);
            2: return $urandom_range(32769, 65535);
            default: return $urandom_range(0, 32768);
        endcase
    endfunction

    // Random word: half near-unit pairs, some near-parallel, some full-range noise.
    function automatic in_word_t random_word();
        int sa[4];
        int sb[4];
        int sel;
        int flip;
        sel  = $urandom_range(0, 9);
        flip = $urandom_range(0, 1);
        for (int i = 0; i < 4; i++)
        begin
            if (sel < 5)
            begin
                sa[i] = $signed($urandom_range(0, 16384)) - 8192;
                sb[i] = $signed($urandom_range(0, 16384)) - 8192;
            end
            else if (sel < 8)
            begin
                sa[i] = $signed($urandom_range(0, 16384)) - 8192;
                sb[i] = sa[i] + $signed($urandom_range(0, 64)) - 32;
                if (flip) sb[i] = -sb[i];
            end
            else
            begin
                sa[i] = $signed($urandom_range(0, 65535)) - 32768;
                sb[i] = $signed($urandom_range(0, 65535)) - 32768;
            end
        end
        return make_word(sa, sb, pick_blend());
    endfunction

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 60 == 0) no_idle = ($urandom_range(0, 3) == 0);
            send_word(random_word());
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        no_idle   = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, short path, parallel, orthogonal, blend ends.
        send_word(make_word('{16384, 0, 0, 0}, '{0, 16384, 0, 0}, 16384));
        send_word(make_word('{16384, 0, 0, 0}, '{16384, 0, 0, 0}, 12000));
        send_word(make_word('{16384, 0, 0, 0}, '{-16384, 0, 0, 0}, 12000));
        send_word(make_word('{0, 0, 0, 16384}, '{0, 11585, 0, 11585}, 0));
        send_word(make_word('{0, 0, 0, 16384}, '{0, 11585, 0, 11585}, 32768));
        send_word(make_word('{0, 0, 0, 16384}, '{0, 11585, 0, -11585}, 65535));
        send_word(make_word('{0, 0, 0, 16384}, '{0, 11585, 0, 11585}, 32769));
        send_word(make_word('{32767, 32767, 32767, 32767}, '{32767, 32767, 32767, 32767}, 16384));
        send_word(make_word('{-32768, -32768, -32768, -32768}, '{32767, 32767, 32767, 32767}, 20000));
        send_word(make_word('{-32768, -32768, -32768, -32768}, '{-32768, -32768, -32768, -32768}, 32768));
        send_word(make_word('{32767, -32768, 32767, -32768}, '{-32768, 32767, 32767, -32768}, 8000));
        send_word(make_word('{0, 0, 0, 0}, '{0, 0, 0, 0}, 16384));
        send_word(make_word('{0, 0, 0, 0}, '{16384, 0, 0, 0}, 30000));
        send_word(make_word('{16384, 0, 0, 0}, '{16383, 180, 0, 0}, 16384));
        send_word(make_word('{16384, 0, 0, 0}, '{16384, 1, 0, 0}, 16384));
        send_word(make_word('{8192, 8192, 8192, 8192}, '{-8192, 8192, -8192, 8192}, 4096));
        send_word(make_word('{8192, 8192, 8192, 8192}, '{-8192, -8000, -8192, 8192}, 28000));
        send_word(make_word('{1, -1, 1, -1}, '{-1, 1, -1, 1}, 1));

        run_random(250);

        // Walk the threshold through its extremes and some middle values.
        drain();
        write_threshold(15'd0);
        run_random(160);
        drain();
        write_threshold(15'd16384);
        run_random(160);
        drain();
        write_threshold(15'd32767);
        send_word(make_word('{32767, 32767, 32767, 32767}, '{32767, 32767, 32767, 32767}, 16384));
        run_random(160);
        drain();
        write_threshold(15'($urandom_range(15000, 16384)));
        run_random(160);
        drain();
        write_threshold(THR_RESET);
        run_random(150);

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
        if (fail_count == 0)
            $display("[quaternion_slerp] OK");
        else
            $display("[quaternion_slerp] ERROR");
        $finish;
    end
endmodule
